[hw/rtl/dttc_pkg.sv]
// ----------------------------------------------------------------------------
// dttc_pkg
// Types, constants and the lane popcount shared by the transition /
// transversion counter.
// ----------------------------------------------------------------------------
package dttc_pkg;

   localparam int unsigned WORD_WIDTH  = 64;
   localparam int unsigned MAX_BASES   = 32;
   localparam int unsigned OUT_WIDTH   = 32;
   // enough bits to count every lane of a full word
   localparam int unsigned LANE_CNT_W  = 6;

   localparam logic [31:0] MASK_PAIRS  = 32'h5555_5555;
   localparam logic [31:0] MASK_NIBS   = 32'h3333_3333;
   localparam logic [31:0] MASK_BYTES  = 32'h0f0f_0f0f;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] seq_a_word;
      logic [WORD_WIDTH-1:0] seq_b_word;
      logic [WORD_WIDTH-1:0] unknown_a_word;
      logic [WORD_WIDTH-1:0] unknown_b_word;
      logic                  last_word;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] transition_count;
      logic [OUT_WIDTH-1:0] transversion_count;
      logic [OUT_WIDTH-1:0] unknown_count;
   } rsp_payload_type;

   typedef struct packed {
      logic [LANE_CNT_W-1:0] transition_ones;
      logic [LANE_CNT_W-1:0] transversion_ones;
      logic [LANE_CNT_W-1:0] unknown_ones;
   } lane_counts_type;

   // swar popcount over one bit per base
   function automatic logic [LANE_CNT_W-1:0] lane_ones(input logic [MAX_BASES-1:0] x);
      logic [31:0] s1;
      logic [31:0] s2;
      logic [31:0] s3;
      logic [LANE_CNT_W-1:0] total;
      s1 = x - ((x >> 1) & MASK_PAIRS);
      s2 = (s1 & MASK_NIBS) + ((s1 >> 2) & MASK_NIBS);
      s3 = (s2 + (s2 >> 4)) & MASK_BYTES;
      total = s3[LANE_CNT_W-1:0] + s3[8 +: LANE_CNT_W]
            + s3[16 +: LANE_CNT_W] + s3[24 +: LANE_CNT_W];
      return total;
   endfunction

endpackage

[hw/rtl/dttc_if.sv]
// ----------------------------------------------------------------------------
// dttc request / response channels
// Valid / ready channels carrying the word pair and the emitted totals.
// ----------------------------------------------------------------------------
interface dttc_req_if;
   import dttc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface dttc_rsp_if;
   import dttc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/dttc_lane_count.sv]
// ----------------------------------------------------------------------------
// dttc_lane_count
// Classifies the bases below BASES_PER_WORD of a word pair and counts
// transitions, transversions and unknown positions.
// ----------------------------------------------------------------------------
module dttc_lane_count #(
   parameter int unsigned BASES_PER_WORD = 32
) (
   input  dttc_pkg::req_payload_type word,
   output dttc_pkg::lane_counts_type counts
);
   import dttc_pkg::*;

   logic [WORD_WIDTH-1:0] unk;
   logic [WORD_WIDTH-1:0] diff;
   logic [MAX_BASES-1:0]  ts_lanes;
   logic [MAX_BASES-1:0]  tv_lanes;
   logic [MAX_BASES-1:0]  un_lanes;

   assign unk  = word.unknown_a_word | word.unknown_b_word;
   assign diff = (word.seq_a_word ^ word.seq_b_word) & ~unk;

   always_comb begin
      for (int i = 0; i < MAX_BASES; i++) begin
         if (i < BASES_PER_WORD) begin
            tv_lanes[i] = diff[2*i+1];
            ts_lanes[i] = diff[2*i] & ~diff[2*i+1];
            un_lanes[i] = unk[2*i];
         end else begin
            tv_lanes[i] = 1'b0;
            ts_lanes[i] = 1'b0;
            un_lanes[i] = 1'b0;
         end
      end
   end

   assign counts.transition_ones   = lane_ones(ts_lanes);
   assign counts.transversion_ones = lane_ones(tv_lanes);
   assign counts.unknown_ones      = lane_ones(un_lanes);

endmodule

[hw/rtl/dttc_accum.sv]
// ----------------------------------------------------------------------------
// dttc_accum
// Saturating totals and the result register; clears the totals on the
// last word of a pair.
// ----------------------------------------------------------------------------
module dttc_accum #(
   parameter int unsigned COUNT_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       word_valid,
   input  logic                       word_last,
   input  dttc_pkg::lane_counts_type  counts,
   output logic                       advance,
   output logic                       out_valid,
   input  logic                       out_ready,
   output dttc_pkg::rsp_payload_type  out_payload
);
   import dttc_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [COUNT_WIDTH-1:0] ts_total_ff, ts_total_in;
   logic [COUNT_WIDTH-1:0] tv_total_ff, tv_total_in;
   logic [COUNT_WIDTH-1:0] un_total_ff, un_total_in;
   logic [COUNT_WIDTH-1:0] ts_sum, tv_sum, un_sum;
   logic                   out_valid_ff, out_valid_in;
   rsp_payload_type        out_payload_ff, out_payload_in;

   function automatic logic [COUNT_WIDTH-1:0] sat_add(
      input logic [COUNT_WIDTH-1:0] acc,
      input logic [LANE_CNT_W-1:0]  n
   );
      logic [COUNT_WIDTH:0] s;
      s = {1'b0, acc} + (COUNT_WIDTH+1)'(n);
      return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
   endfunction

   // a last word may only move on once the result register can take it
   assign advance = word_valid & (~word_last | ~out_valid_ff | out_ready);

   assign ts_sum = sat_add(ts_total_ff, counts.transition_ones);
   assign tv_sum = sat_add(tv_total_ff, counts.transversion_ones);
   assign un_sum = sat_add(un_total_ff, counts.unknown_ones);

   always_comb begin
      ts_total_in    = ts_total_ff;
      tv_total_in    = tv_total_ff;
      un_total_in    = un_total_ff;
      out_valid_in   = out_valid_ff & ~out_ready;
      out_payload_in = out_payload_ff;
      if (advance) begin
         if (word_last) begin
            ts_total_in    = '0;
            tv_total_in    = '0;
            un_total_in    = '0;
            out_valid_in   = 1'b1;
            out_payload_in.transition_count   = OUT_WIDTH'(ts_sum);
            out_payload_in.transversion_count = OUT_WIDTH'(tv_sum);
            out_payload_in.unknown_count      = OUT_WIDTH'(un_sum);
         end else begin
            ts_total_in = ts_sum;
            tv_total_in = tv_sum;
            un_total_in = un_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_total_ff  <= '0;
         tv_total_ff  <= '0;
         un_total_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         ts_total_ff  <= ts_total_in;
         tv_total_ff  <= tv_total_in;
         un_total_ff  <= un_total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_payload_ff <= out_payload_in;
   end

   assign out_valid   = out_valid_ff;
   assign out_payload = out_payload_ff;

endmodule

[hw/rtl/dna_transition_transversion_counter.sv]
// ----------------------------------------------------------------------------
// dna_transition_transversion_counter
// Counts transitions, transversions and unknown positions between two
// aligned 2-bit-per-base DNA sequences and reports the totals per pair.
// ----------------------------------------------------------------------------
// One word pair is accepted every clock unless stalled. A word goes into an
// input register, its three lane popcounts feed the saturating totals in the
// next cycle, and a word marked last loads the result register and clears
// the totals, so the totals reach the result register as the last word
// advances. The popcount tree plus one counter add and saturate sets the
// clock-to-clock path. The input stalls only while a last word waits behind
// a result that has not yet been taken. Counters are COUNT_WIDTH bits and
// saturate at all ones; bases at and above BASES_PER_WORD are ignored.
module dna_transition_transversion_counter #(
   parameter int unsigned BASES_PER_WORD = 32,
   parameter int unsigned COUNT_WIDTH    = 32
) (
   input  logic        clock,
   input  logic        reset,
   dttc_req_if.sink    req_if,
   dttc_rsp_if.source  rsp_if
);
   import dttc_pkg::*;

   logic            word_valid_ff, word_valid_in;
   req_payload_type word_ff;
   lane_counts_type counts;
   logic            advance;
   logic            req_take;

   assign req_if.ready  = ~word_valid_ff | advance;
   assign req_take      = req_if.valid & req_if.ready;
   assign word_valid_in = req_take | (word_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         word_ff <= req_if.payload;
      end
   end

   dttc_lane_count #(
      .BASES_PER_WORD (BASES_PER_WORD)
   ) u_lane_count (
      .word   (word_ff),
      .counts (counts)
   );

   dttc_accum #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .word_valid  (word_valid_ff),
      .word_last   (word_ff.last_word),
      .counts      (counts),
      .advance     (advance),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_payload (rsp_if.payload)
   );

endmodule
